[sv/htm_pkg.sv]
`default_nettype none

package htm_pkg;

    // Mesh limits and field widths
    localparam int MAX_CELLS_PER_AXIS = 1024;
    localparam int CNT_W    = $clog2(MAX_CELLS_PER_AXIS + 1);
    localparam int COORD_W  = 10;
    localparam int KIND_W   = 3;
    localparam int NODE_W   = 31;
    localparam int ID_W     = 33;
    localparam int TAG_W    = 8;
    localparam int OWNER_W  = 16;
    localparam int STRIDE_W = $clog2((MAX_CELLS_PER_AXIS + 1) * (MAX_CELLS_PER_AXIS + 1) + 1);
    localparam int AREA_W   = $clog2(MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS + 1);
    localparam int LOC_W    = $clog2(MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS);
    localparam int VOL_W    = $clog2(MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS + 1);
    localparam int FACEK_W  = $clog2(10 * MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS + 1);

    // Register port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Decoupling queue and settle time of the derived geometry
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int PEND_W     = $clog2(QDEPTH + 1);
    localparam int CFG_SETTLE = 4;
    localparam int SETTLE_W   = $clog2(CFG_SETTLE + 1);

    // Result sequencing
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_LAST_CELL = 3'd4;
    localparam logic [STEP_W-1:0] STEP_LAST_FACE = 3'd1;
    localparam logic [2:0]        TETS_PER_CELL  = 3'd5;

    // Boundary tags
    localparam logic [TAG_W-1:0] TAG_CELL   = 8'd0;
    localparam logic [TAG_W-1:0] TAG_BOTTOM = 8'd100;
    localparam logic [TAG_W-1:0] TAG_TOP    = 8'd200;
    localparam logic [TAG_W-1:0] TAG_LEFT   = 8'd1;
    localparam logic [TAG_W-1:0] TAG_RIGHT  = 8'd2;
    localparam logic [TAG_W-1:0] TAG_FRONT  = 8'd10;
    localparam logic [TAG_W-1:0] TAG_BACK   = 8'd20;

    typedef enum logic [KIND_W-1:0] {
        KIND_CELL   = 3'd0,
        KIND_BOTTOM = 3'd1,
        KIND_TOP    = 3'd2,
        KIND_LEFT   = 3'd3,
        KIND_RIGHT  = 3'd4,
        KIND_FRONT  = 3'd5,
        KIND_BACK   = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        REG_CELLS_X = 2'd0,
        REG_CELLS_Y = 2'd1,
        REG_CELLS_Z = 2'd2,
        REG_OWNER   = 2'd3
    } reg_idx_t;

    // Geometry derived from the cell counts
    typedef struct packed {
        logic [CNT_W-1:0]    nx;
        logic [CNT_W-1:0]    ny;
        logic [CNT_W-1:0]    nz;
        logic [AREA_W-1:0]   nxny;
        logic [STRIDE_W-1:0] s0;
        logic [STRIDE_W-1:0] s1;
        logic [STRIDE_W-1:0] s2;
        logic [STRIDE_W-1:0] s01;
        logic [STRIDE_W-1:0] s02;
        logic [STRIDE_W-1:0] s12;
        logic [STRIDE_W-1:0] s012;
        logic [ID_W-1:0]     off_bottom;
        logic [ID_W-1:0]     off_top;
        logic [ID_W-1:0]     off_left;
        logic [ID_W-1:0]     off_right;
        logic [ID_W-1:0]     off_front;
        logic [ID_W-1:0]     off_back;
    } geom_t;

    // One classified request as handed from front to back
    typedef struct packed {
        kind_t             kind;
        logic              bad;
        logic              even;
        logic [NODE_W-1:0] n;
        logic [ID_W-1:0]   id;
    } job_t;

    typedef logic [2:0]       corner_t;
    typedef logic [3:0][2:0]  corners_t;

    // Corner indices (bit0 first axis, bit1 second, bit2 third) of one result.
    // Slot 3 is node_a. Cell shapes are given in the plain orientation.
    function automatic corners_t corner_set(kind_t kind, logic even,
                                            logic [STEP_W-1:0] step);
        corners_t   cs;
        logic [1:0] sel;
        sel = {even, step[0]};
        cs  = '0;
        case (kind)
            KIND_CELL:
            begin
                case (step)
                    3'd0:    cs = {3'd4, 3'd5, 3'd6, 3'd0};
                    3'd1:    cs = {3'd7, 3'd6, 3'd5, 3'd3};
                    3'd2:    cs = {3'd2, 3'd3, 3'd0, 3'd6};
                    3'd3:    cs = {3'd1, 3'd0, 3'd3, 3'd5};
                    default: cs = {3'd5, 3'd0, 3'd6, 3'd3};
                endcase
            end
            KIND_BOTTOM:
            begin
                case (sel)
                    2'b10:   cs = {3'd0, 3'd3, 3'd1, 3'd0};
                    2'b11:   cs = {3'd0, 3'd2, 3'd3, 3'd0};
                    2'b00:   cs = {3'd0, 3'd2, 3'd1, 3'd0};
                    default: cs = {3'd1, 3'd2, 3'd3, 3'd0};
                endcase
            end
            KIND_TOP:
            begin
                case (sel)
                    2'b10:   cs = {3'd4, 3'd5, 3'd6, 3'd0};
                    2'b11:   cs = {3'd5, 3'd7, 3'd6, 3'd0};
                    2'b00:   cs = {3'd4, 3'd5, 3'd7, 3'd0};
                    default: cs = {3'd4, 3'd7, 3'd6, 3'd0};
                endcase
            end
            KIND_LEFT:
            begin
                case (sel)
                    2'b10:   cs = {3'd0, 3'd4, 3'd6, 3'd0};
                    2'b11:   cs = {3'd0, 3'd6, 3'd2, 3'd0};
                    2'b00:   cs = {3'd0, 3'd4, 3'd2, 3'd0};
                    default: cs = {3'd4, 3'd6, 3'd2, 3'd0};
                endcase
            end
            KIND_RIGHT:
            begin
                case (sel)
                    2'b10:   cs = {3'd1, 3'd3, 3'd5, 3'd0};
                    2'b11:   cs = {3'd3, 3'd7, 3'd5, 3'd0};
                    2'b00:   cs = {3'd1, 3'd7, 3'd5, 3'd0};
                    default: cs = {3'd1, 3'd3, 3'd7, 3'd0};
                endcase
            end
            KIND_FRONT:
            begin
                case (sel)
                    2'b10:   cs = {3'd0, 3'd1, 3'd5, 3'd0};
                    2'b11:   cs = {3'd0, 3'd5, 3'd4, 3'd0};
                    2'b00:   cs = {3'd0, 3'd1, 3'd4, 3'd0};
                    default: cs = {3'd1, 3'd5, 3'd4, 3'd0};
                endcase
            end
            default:
            begin
                case (sel)
                    2'b10:   cs = {3'd2, 3'd6, 3'd3, 3'd0};
                    2'b11:   cs = {3'd6, 3'd7, 3'd3, 3'd0};
                    2'b00:   cs = {3'd2, 3'd6, 3'd7, 3'd0};
                    default: cs = {3'd2, 3'd7, 3'd3, 3'd0};
                endcase
            end
        endcase
        return cs;
    endfunction

    function automatic logic [TAG_W-1:0] tag_of(kind_t kind);
        logic [TAG_W-1:0] t;
        case (kind)
            KIND_BOTTOM: t = TAG_BOTTOM;
            KIND_TOP:    t = TAG_TOP;
            KIND_LEFT:   t = TAG_LEFT;
            KIND_RIGHT:  t = TAG_RIGHT;
            KIND_FRONT:  t = TAG_FRONT;
            KIND_BACK:   t = TAG_BACK;
            default:     t = TAG_CELL;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

[sv/hex_to_tet_mesh_connectivity_unit.sv]
`default_nettype none

// Tetrahedral connectivity of a structured brick mesh. Each request beat names
// a cell (kind 0) or a boundary face square (kinds 1..6: bottom, top, left,
// right, front, back) by global cell coordinates; the unit returns five
// tetrahedra for a cell, two triangles for a face, or one result with
// bad_request set when a used coordinate is outside the configured counts or
// the kind is unused. last marks the final result beat of each request.
// Results leave one beat per cycle from an output register while res_stall is
// low. Requests are classified in a three-stage front pipeline (range check,
// stride and index multiplies, node base and element id) and parked in a
// 4-entry queue; the front accepts a new beat every cycle while fewer than 4
// requests are pending between accept and completion, so result backpressure
// stalls the request side only once the queue fills. Node strides and face id
// offsets are recomputed by a 4-stage register pipeline after every register
// write and after reset; req_stall is held high while they settle. Register
// writes must be issued only while the unit is idle. Registers: cells_x at 0x0,
// cells_y at 0x4, cells_z at 0x8 (written 0 reads as 1, above 1024 saturates to
// 1024) and owner_rank at 0xC.
module hex_to_tet_mesh_connectivity_unit (
    input  wire                          clk,
    input  wire                          rst_n,
    // register port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [htm_pkg::ADDR_W-1:0]   paddr,
    input  wire  [htm_pkg::DATA_W-1:0]   pwdata,
    output logic [htm_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    // request channel
    input  wire                          req_valid,
    output logic                         req_stall,
    input  wire  [htm_pkg::KIND_W-1:0]   kind,
    input  wire  [htm_pkg::COORD_W-1:0]  cell_x,
    input  wire  [htm_pkg::COORD_W-1:0]  cell_y,
    input  wire  [htm_pkg::COORD_W-1:0]  cell_z,
    // result channel
    output logic                         res_valid,
    input  wire                          res_stall,
    output logic [htm_pkg::ID_W-1:0]     element_id,
    output logic [htm_pkg::NODE_W-1:0]   node_a,
    output logic [htm_pkg::NODE_W-1:0]   node_b,
    output logic [htm_pkg::NODE_W-1:0]   node_c,
    output logic [htm_pkg::NODE_W-1:0]   node_d,
    output logic [htm_pkg::TAG_W-1:0]    tag,
    output logic [htm_pkg::OWNER_W-1:0]  owner,
    output logic                         bad_request,
    output logic                         last
);
    import htm_pkg::*;

    geom_t              geom;
    logic [OWNER_W-1:0] owner_rank;
    logic               cfg_busy;
    logic               q_push, q_pop, q_empty;
    job_t               q_job, q_head;

    // Register file and derived geometry
    htm_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .geom       (geom),
        .owner_rank (owner_rank),
        .busy       (cfg_busy)
    );

    // Classify requests: range check, node base and first element id
    htm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .kind      (kind),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .cell_z    (cell_z),
        .geom      (geom),
        .cfg_busy  (cfg_busy),
        .q_pop     (q_pop),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    // Decouple classification from result emission
    htm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_job),
        .pop   (q_pop),
        .head  (q_head),
        .empty (q_empty)
    );

    // Walk each queued request out as tetrahedra or triangles
    htm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .head        (q_head),
        .q_pop       (q_pop),
        .geom        (geom),
        .owner_rank  (owner_rank),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .element_id  (element_id),
        .node_a      (node_a),
        .node_b      (node_b),
        .node_c      (node_c),
        .node_d      (node_d),
        .tag         (tag),
        .owner       (owner),
        .bad_request (bad_request),
        .last        (last)
    );

    // A request leaves the queue only when it is there
    a_pop_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // Retiring a request loads its final beat into the output register
    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> res_valid && last)
        else $error("request retired without a last beat");

    // An error result is a single beat with cleared payload
    a_bad_is_single: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && bad_request |-> last && element_id == '0 && node_a == '0
            && node_d == '0 && tag == '0)
        else $error("error result carries payload or is not last");

endmodule

`default_nettype wire

[sv/htm_cfg.sv]
`default_nettype none

module htm_cfg (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [htm_pkg::ADDR_W-1:0]   paddr,
    input  wire  [htm_pkg::DATA_W-1:0]   pwdata,
    output logic [htm_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output htm_pkg::geom_t               geom,
    output logic [htm_pkg::OWNER_W-1:0]  owner_rank,
    output logic                         busy
);
    import htm_pkg::*;

    logic [CNT_W-1:0]    cells_x_reg, cells_x_next;
    logic [CNT_W-1:0]    cells_y_reg, cells_y_next;
    logic [CNT_W-1:0]    cells_z_reg, cells_z_next;
    logic [OWNER_W-1:0]  owner_reg, owner_next;
    logic [SETTLE_W-1:0] settle_reg, settle_next;

    logic                wr;
    reg_idx_t            widx;
    logic [CNT_W-1:0]    wcount;

    // Stage 1: pairwise products
    logic [2*CNT_W-1:0]  nxny_p, nynz_p, nxnz_p, n0n1_p, n0n2_p, n1n2_p;
    logic [CNT_W-1:0]    n0, n1, n2;
    logic [AREA_W-1:0]   nxny_reg, nynz_reg, nxnz_reg;
    logic [STRIDE_W-1:0] n0n1_reg, n0n2_reg, n1n2_reg;
    // Stage 2: strides and volume
    logic [STRIDE_W-1:0] s0_reg, s1_reg, s2_reg;
    logic [STRIDE_W-1:0] s0_next, s1_next, s2_next;
    logic [AREA_W+CNT_W-1:0] vol_p;
    logic [VOL_W-1:0]    vol_reg;
    // Stage 3: stride sums, tetrahedron count, face block sizes
    logic [STRIDE_W-1:0] s01_reg, s02_reg, s12_reg, s012_reg;
    logic [ID_W-1:0]     base_reg;
    logic [FACEK_W-1:0]  k_top_reg, k_left_reg, k_right_reg, k_front_reg, k_back_reg;
    // Stage 4: face id offsets
    logic [ID_W-1:0]     off_top_reg, off_left_reg, off_right_reg;
    logic [ID_W-1:0]     off_front_reg, off_back_reg;

    assign wr     = psel && penable && pwrite;
    assign widx   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign pready = 1'b1;

    // Clamp a written count into 1..MAX_CELLS_PER_AXIS
    always_comb
    begin
        wcount = pwdata[CNT_W-1:0];
        if (wcount == '0)
        begin
            wcount = CNT_W'(1);
        end
        else if (wcount > CNT_W'(MAX_CELLS_PER_AXIS))
        begin
            wcount = CNT_W'(MAX_CELLS_PER_AXIS);
        end
    end

    always_comb
    begin
        cells_x_next = cells_x_reg;
        cells_y_next = cells_y_reg;
        cells_z_next = cells_z_reg;
        owner_next   = owner_reg;
        settle_next  = (settle_reg != '0) ? settle_reg - SETTLE_W'(1) : settle_reg;
        if (wr)
        begin
            settle_next = SETTLE_W'(CFG_SETTLE);
            case (widx)
                REG_CELLS_X: cells_x_next = wcount;
                REG_CELLS_Y: cells_y_next = wcount;
                REG_CELLS_Z: cells_z_next = wcount;
                REG_OWNER:   owner_next   = pwdata[OWNER_W-1:0];
                default:     owner_next   = owner_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_x_reg <= CNT_W'(1);
            cells_y_reg <= CNT_W'(1);
            cells_z_reg <= CNT_W'(1);
            owner_reg   <= '0;
            settle_reg  <= SETTLE_W'(CFG_SETTLE);
        end
        else
        begin
            cells_x_reg <= cells_x_next;
            cells_y_reg <= cells_y_next;
            cells_z_reg <= cells_z_next;
            owner_reg   <= owner_next;
            settle_reg  <= settle_next;
        end
    end

    always_comb
    begin
        case (widx)
            REG_CELLS_X: prdata = DATA_W'(cells_x_reg);
            REG_CELLS_Y: prdata = DATA_W'(cells_y_reg);
            REG_CELLS_Z: prdata = DATA_W'(cells_z_reg);
            REG_OWNER:   prdata = DATA_W'(owner_reg);
            default:     prdata = '0;
        endcase
    end

    assign n0 = cells_x_reg + CNT_W'(1);
    assign n1 = cells_y_reg + CNT_W'(1);
    assign n2 = cells_z_reg + CNT_W'(1);

    assign nxny_p = cells_x_reg * cells_y_reg;
    assign nynz_p = cells_y_reg * cells_z_reg;
    assign nxnz_p = cells_x_reg * cells_z_reg;
    assign n0n1_p = n0 * n1;
    assign n0n2_p = n0 * n2;
    assign n1n2_p = n1 * n2;

    // The axis with the most nodes goes outermost; ties favor the third axis
    always_comb
    begin
        if (cells_z_reg >= cells_x_reg && cells_z_reg >= cells_y_reg)
        begin
            s0_next = STRIDE_W'(1);
            s1_next = STRIDE_W'(n0);
            s2_next = n0n1_reg;
        end
        else if (cells_y_reg >= cells_x_reg && cells_y_reg >= cells_z_reg)
        begin
            s0_next = STRIDE_W'(n2);
            s1_next = n0n2_reg;
            s2_next = STRIDE_W'(1);
        end
        else
        begin
            s0_next = n1n2_reg;
            s1_next = STRIDE_W'(1);
            s2_next = STRIDE_W'(n1);
        end
    end

    assign vol_p = nxny_reg * cells_z_reg;

    always_ff @(posedge clk)
    begin
        nxny_reg <= nxny_p[AREA_W-1:0];
        nynz_reg <= nynz_p[AREA_W-1:0];
        nxnz_reg <= nxnz_p[AREA_W-1:0];
        n0n1_reg <= n0n1_p[STRIDE_W-1:0];
        n0n2_reg <= n0n2_p[STRIDE_W-1:0];
        n1n2_reg <= n1n2_p[STRIDE_W-1:0];

        s0_reg  <= s0_next;
        s1_reg  <= s1_next;
        s2_reg  <= s2_next;
        vol_reg <= vol_p[VOL_W-1:0];

        s01_reg     <= s0_reg + s1_reg;
        s02_reg     <= s0_reg + s2_reg;
        s12_reg     <= s1_reg + s2_reg;
        s012_reg    <= s0_reg + s1_reg + s2_reg;
        base_reg    <= (ID_W'(vol_reg) << 2) + ID_W'(vol_reg);
        k_top_reg   <= FACEK_W'(nxny_reg) << 1;
        k_left_reg  <= FACEK_W'(nxny_reg) << 2;
        k_right_reg <= (FACEK_W'(nxny_reg) << 2) + (FACEK_W'(nynz_reg) << 1);
        k_front_reg <= (FACEK_W'(nxny_reg) << 2) + (FACEK_W'(nynz_reg) << 2);
        k_back_reg  <= (FACEK_W'(nxny_reg) << 2) + (FACEK_W'(nynz_reg) << 2)
                       + (FACEK_W'(nxnz_reg) << 1);

        off_top_reg   <= base_reg + ID_W'(k_top_reg);
        off_left_reg  <= base_reg + ID_W'(k_left_reg);
        off_right_reg <= base_reg + ID_W'(k_right_reg);
        off_front_reg <= base_reg + ID_W'(k_front_reg);
        off_back_reg  <= base_reg + ID_W'(k_back_reg);
    end

    always_comb
    begin
        geom.nx         = cells_x_reg;
        geom.ny         = cells_y_reg;
        geom.nz         = cells_z_reg;
        geom.nxny       = nxny_reg;
        geom.s0         = s0_reg;
        geom.s1         = s1_reg;
        geom.s2         = s2_reg;
        geom.s01        = s01_reg;
        geom.s02        = s02_reg;
        geom.s12        = s12_reg;
        geom.s012       = s012_reg;
        geom.off_bottom = base_reg;
        geom.off_top    = off_top_reg;
        geom.off_left   = off_left_reg;
        geom.off_right  = off_right_reg;
        geom.off_front  = off_front_reg;
        geom.off_back   = off_back_reg;
    end

    assign owner_rank = owner_reg;
    assign busy       = (settle_reg != '0);

endmodule

`default_nettype wire

[sv/htm_front.sv]
`default_nettype none

module htm_front (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          req_valid,
    output logic                         req_stall,
    input  wire  [htm_pkg::KIND_W-1:0]   kind,
    input  wire  [htm_pkg::COORD_W-1:0]  cell_x,
    input  wire  [htm_pkg::COORD_W-1:0]  cell_y,
    input  wire  [htm_pkg::COORD_W-1:0]  cell_z,
    input  htm_pkg::geom_t               geom,
    input  wire                          cfg_busy,
    input  wire                          q_pop,
    output logic                         q_push,
    output htm_pkg::job_t                q_job
);
    import htm_pkg::*;

    logic              accept;
    kind_t             kin;
    logic [PEND_W-1:0] pending_reg, pending_next;

    // Decode at the input
    logic               bad0, even0;
    logic [COORD_W-1:0] ex0, ey0, ez0, a0, b0, c0;
    logic [CNT_W-1:0]   m1_0;
    logic [AREA_W-1:0]  m2_0;

    // Stage 1
    logic               v1_reg;
    kind_t              kind1_reg;
    logic               bad1_reg, even1_reg;
    logic [COORD_W-1:0] ex1_reg, ey1_reg, ez1_reg, a1_reg, b1_reg, c1_reg;
    logic [CNT_W-1:0]   m1_1_reg;
    logic [AREA_W-1:0]  m2_1_reg;

    // Stage 2
    logic [STRIDE_W+COORD_W-1:0] prod0, prod1, prod2;
    logic [CNT_W+COORD_W-1:0]    prodq1;
    logic [AREA_W+COORD_W-1:0]   prodq2;
    logic               v2_reg;
    kind_t              kind2_reg;
    logic               bad2_reg, even2_reg;
    logic [NODE_W-1:0]  p0_reg, p1_reg, p2_reg;
    logic [COORD_W-1:0] a2_reg;
    logic [AREA_W-1:0]  q1_reg;
    logic [LOC_W-1:0]   q2_reg;

    // Stage 3
    logic               v3_reg;
    kind_t              kind3_reg;
    logic               bad3_reg, even3_reg;
    logic [NODE_W-1:0]  n3_reg;
    logic [LOC_W-1:0]   loc3_reg;
    logic [ID_W-1:0]    face_off;

    assign kin       = kind_t'(kind);
    assign req_stall = (pending_reg == PEND_W'(QDEPTH)) || cfg_busy;
    assign accept    = req_valid && !req_stall;

    // Count items between accept and pop so the queue never overflows
    always_comb
    begin
        pending_next = pending_reg;
        if (accept && !q_pop)
        begin
            pending_next = pending_reg + PEND_W'(1);
        end
        else if (!accept && q_pop)
        begin
            pending_next = pending_reg - PEND_W'(1);
        end
    end

    // Range check, effective corner coordinates and id operands per kind
    always_comb
    begin
        bad0 = 1'b0;
        ex0  = cell_x;
        ey0  = cell_y;
        ez0  = cell_z;
        a0   = cell_x;
        m1_0 = geom.nx;
        b0   = cell_y;
        m2_0 = '0;
        c0   = '0;
        case (kin)
            KIND_CELL:
            begin
                bad0 = ({1'b0, cell_x} >= geom.nx) || ({1'b0, cell_y} >= geom.ny)
                       || ({1'b0, cell_z} >= geom.nz);
                m2_0 = geom.nxny;
                c0   = cell_z;
            end
            KIND_BOTTOM, KIND_TOP:
            begin
                bad0 = ({1'b0, cell_x} >= geom.nx) || ({1'b0, cell_y} >= geom.ny);
                ez0  = (kin == KIND_TOP) ? COORD_W'(geom.nz - CNT_W'(1)) : '0;
            end
            KIND_LEFT, KIND_RIGHT:
            begin
                bad0 = ({1'b0, cell_y} >= geom.ny) || ({1'b0, cell_z} >= geom.nz);
                ex0  = (kin == KIND_RIGHT) ? COORD_W'(geom.nx - CNT_W'(1)) : '0;
                a0   = cell_y;
                m1_0 = geom.ny;
                b0   = cell_z;
            end
            KIND_FRONT, KIND_BACK:
            begin
                bad0 = ({1'b0, cell_x} >= geom.nx) || ({1'b0, cell_z} >= geom.nz);
                ey0  = (kin == KIND_BACK) ? COORD_W'(geom.ny - CNT_W'(1)) : '0;
                a0   = cell_z;
                m1_0 = geom.nz;
                b0   = cell_x;
            end
            default:
            begin
                bad0 = 1'b1;
            end
        endcase
        even0 = ~(ex0[0] ^ ey0[0] ^ ez0[0]);
    end

    assign prod0  = geom.s0 * ex1_reg;
    assign prod1  = geom.s1 * ey1_reg;
    assign prod2  = geom.s2 * ez1_reg;
    assign prodq1 = m1_1_reg * b1_reg;
    assign prodq2 = m2_1_reg * c1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            v1_reg      <= accept;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        kind1_reg <= kin;
        bad1_reg  <= bad0;
        even1_reg <= even0;
        ex1_reg   <= ex0;
        ey1_reg   <= ey0;
        ez1_reg   <= ez0;
        a1_reg    <= a0;
        m1_1_reg  <= m1_0;
        b1_reg    <= b0;
        m2_1_reg  <= m2_0;
        c1_reg    <= c0;

        kind2_reg <= kind1_reg;
        bad2_reg  <= bad1_reg;
        even2_reg <= even1_reg;
        p0_reg    <= NODE_W'(prod0);
        p1_reg    <= NODE_W'(prod1);
        p2_reg    <= NODE_W'(prod2);
        a2_reg    <= a1_reg;
        q1_reg    <= prodq1[AREA_W-1:0];
        q2_reg    <= prodq2[LOC_W-1:0];

        kind3_reg <= kind2_reg;
        bad3_reg  <= bad2_reg;
        even3_reg <= even2_reg;
        n3_reg    <= p0_reg + p1_reg + p2_reg;
        loc3_reg  <= LOC_W'(a2_reg) + LOC_W'(q1_reg) + q2_reg;
    end

    always_comb
    begin
        case (kind3_reg)
            KIND_TOP:   face_off = geom.off_top;
            KIND_LEFT:  face_off = geom.off_left;
            KIND_RIGHT: face_off = geom.off_right;
            KIND_FRONT: face_off = geom.off_front;
            KIND_BACK:  face_off = geom.off_back;
            default:    face_off = geom.off_bottom;
        endcase
    end

    // Five tetrahedra per cell, two triangles per face square
    always_comb
    begin
        q_job.kind = kind3_reg;
        q_job.bad  = bad3_reg;
        q_job.even = even3_reg;
        q_job.n    = n3_reg;
        if (kind3_reg == KIND_CELL)
        begin
            q_job.id = (ID_W'(loc3_reg) << 2) + ID_W'(loc3_reg);
        end
        else
        begin
            q_job.id = face_off + (ID_W'(loc3_reg) << 1);
        end
    end

    assign q_push = v3_reg;

endmodule

`default_nettype wire

[sv/htm_queue.sv]
`default_nettype none

module htm_queue (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            push,
    input  htm_pkg::job_t  wdata,
    input  wire            pop,
    output htm_pkg::job_t  head,
    output logic           empty
);
    import htm_pkg::*;

    job_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [PEND_W-1:0] count_reg, count_next;

    // Upstream credit keeps push away from a full queue
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + PEND_W'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - PEND_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= wdata;
        end
    end

    assign head  = entry_reg[rptr_reg];
    assign empty = (count_reg == '0);

endmodule

`default_nettype wire

[sv/htm_back.sv]
`default_nettype none

module htm_back (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          q_empty,
    input  htm_pkg::job_t                head,
    output logic                         q_pop,
    input  htm_pkg::geom_t               geom,
    input  wire  [htm_pkg::OWNER_W-1:0]  owner_rank,
    output logic                         res_valid,
    input  wire                          res_stall,
    output logic [htm_pkg::ID_W-1:0]     element_id,
    output logic [htm_pkg::NODE_W-1:0]   node_a,
    output logic [htm_pkg::NODE_W-1:0]   node_b,
    output logic [htm_pkg::NODE_W-1:0]   node_c,
    output logic [htm_pkg::NODE_W-1:0]   node_d,
    output logic [htm_pkg::TAG_W-1:0]    tag,
    output logic [htm_pkg::OWNER_W-1:0]  owner,
    output logic                         bad_request,
    output logic                         last
);
    import htm_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic              res_valid_reg, res_valid_next;
    logic [ID_W-1:0]   element_id_reg, element_id_next;
    logic [NODE_W-1:0] node_reg [4];
    logic [NODE_W-1:0] node_next [4];
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic              bad_reg, bad_next;
    logic              last_reg, last_next;

    logic              can_load, fire, is_last;
    logic [STEP_W-1:0] last_step;
    corners_t          cs;
    corner_t           cn [4];

    // Odd cells use the pattern turned a quarter about the first axis
    function automatic corner_t rotate_corner(corner_t c);
        return {c[1], ~c[2], c[0]};
    endfunction

    function automatic logic [STRIDE_W-1:0] stride_off(corner_t c, geom_t g);
        logic [STRIDE_W-1:0] o;
        case (c)
            3'd0:    o = '0;
            3'd1:    o = g.s0;
            3'd2:    o = g.s1;
            3'd3:    o = g.s01;
            3'd4:    o = g.s2;
            3'd5:    o = g.s02;
            3'd6:    o = g.s12;
            default: o = g.s012;
        endcase
        return o;
    endfunction

    assign can_load = !res_valid_reg || !res_stall;
    assign fire     = !q_empty && can_load;

    always_comb
    begin
        if (head.bad)
        begin
            last_step = '0;
        end
        else if (head.kind == KIND_CELL)
        begin
            last_step = STEP_LAST_CELL;
        end
        else
        begin
            last_step = STEP_LAST_FACE;
        end
    end

    assign is_last   = (step_reg == last_step);
    assign q_pop     = fire && is_last;
    assign step_next = fire ? (is_last ? '0 : step_reg + STEP_W'(1)) : step_reg;

    assign cs = corner_set(head.kind, head.even, step_reg);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            cn[i] = cs[i];
            if (head.kind == KIND_CELL && !head.even)
            begin
                cn[i] = rotate_corner(cs[i]);
            end
        end
    end

    always_comb
    begin
        res_valid_next  = res_valid_reg;
        element_id_next = element_id_reg;
        tag_next        = tag_reg;
        bad_next        = bad_reg;
        last_next       = last_reg;
        for (int i = 0; i < 4; i++)
        begin
            node_next[i] = node_reg[i];
        end
        if (can_load)
        begin
            res_valid_next = fire;
        end
        if (fire)
        begin
            if (head.bad)
            begin
                element_id_next = '0;
                tag_next        = TAG_CELL;
                bad_next        = 1'b1;
                last_next       = 1'b1;
                for (int i = 0; i < 4; i++)
                begin
                    node_next[i] = '0;
                end
            end
            else
            begin
                element_id_next = head.id + ID_W'(step_reg);
                tag_next        = tag_of(head.kind);
                bad_next        = 1'b0;
                last_next       = is_last;
                for (int i = 0; i < 4; i++)
                begin
                    node_next[i] = head.n + NODE_W'(stride_off(cn[i], geom));
                end
                // Triangles carry no fourth vertex
                if (head.kind != KIND_CELL)
                begin
                    node_next[0] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        element_id_reg <= element_id_next;
        tag_reg        <= tag_next;
        bad_reg        <= bad_next;
        last_reg       <= last_next;
        for (int i = 0; i < 4; i++)
        begin
            node_reg[i] <= node_next[i];
        end
    end

    assign res_valid   = res_valid_reg;
    assign element_id  = element_id_reg;
    assign node_a      = node_reg[3];
    assign node_b      = node_reg[2];
    assign node_c      = node_reg[1];
    assign node_d      = node_reg[0];
    assign tag         = tag_reg;
    assign owner       = owner_rank;
    assign bad_request = bad_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

[dv/tb_hex_to_tet_mesh_connectivity_unit.sv]
`default_nettype none

module tb_hex_to_tet_mesh_connectivity_unit;

    import htm_pkg::*;

    // Kind 7 is not assigned to any cell or face; the block must flag it
    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

    localparam int RESET_CYCLES    = 4;
    localparam int IDLE_PCT        = 13;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 40;
    // Long receiver hold-off, started partway into the first random phase
    localparam int HOLD_AT         = 35;
    localparam int HOLD_CYCLES     = 80;
    // Window of accepted beats during which neither side idles
    localparam int QUIET_FROM      = 200;
    localparam int QUIET_TO        = 280;
    // Cycles to let the classify pipeline and queue empty out
    localparam int DRAIN_CYCLES    = 16;
    localparam int TIMEOUT         = 2_000_000;

    // One result beat as the block presents it
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [NODE_W-1:0]  na;
        logic [NODE_W-1:0]  nb;
        logic [NODE_W-1:0]  nc;
        logic [NODE_W-1:0]  nd;
        logic [TAG_W-1:0]   tg;
        logic [OWNER_W-1:0] own;
        logic               bad;
        logic               lst;
    } elem_t;

    // One row of the directed plan: either a register write or a request,
    // the latter optionally with its first result typed in by hand
    typedef struct packed {
        logic                is_cfg;
        reg_idx_t            ridx;
        logic [DATA_W-1:0]   wdata;
        logic [KIND_W-1:0]   knd;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  z;
        logic                typed;
        elem_t               first;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                req_valid;
    logic                req_stall;
    logic [KIND_W-1:0]   kind;
    logic [COORD_W-1:0]  cell_x;
    logic [COORD_W-1:0]  cell_y;
    logic [COORD_W-1:0]  cell_z;
    logic                res_valid;
    logic                res_stall;
    logic [ID_W-1:0]     element_id;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [NODE_W-1:0]   node_c;
    logic [NODE_W-1:0]   node_d;
    logic [TAG_W-1:0]    tag;
    logic [OWNER_W-1:0]  owner;
    logic                bad_request;
    logic                last;

    // Shadow of the mesh configuration and the strides it implies
    longint unsigned mesh_nx, mesh_ny, mesh_nz;
    logic [OWNER_W-1:0] mesh_owner;
    longint unsigned stride_x, stride_y, stride_z;

    // Elements still owed by the block, oldest first
    elem_t pending_elements[$];
    // Scratch list for the request being predicted; only the sender touches it
    elem_t request_elements[$];
    plan_row_t directed_plan[$];

    int unsigned items_sent = 0;
    int unsigned mismatches = 0;
    int          hold_left  = 0;
    bit          hold_done  = 1'b0;

    hex_to_tet_mesh_connectivity_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .kind        (kind),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .cell_z      (cell_z),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .element_id  (element_id),
        .node_a      (node_a),
        .node_b      (node_b),
        .node_c      (node_c),
        .node_d      (node_d),
        .tag         (tag),
        .owner       (owner),
        .bad_request (bad_request),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Mesh model
    // ------------------------------------------------------------------

    // Cell count as the block stores it: low 11 bits, zero reads as one,
    // anything past the axis limit saturates
    function automatic longint unsigned clamp_count(input logic [DATA_W-1:0] word);
        longint unsigned n;
        n = word[CNT_W-1:0];
        if (n == 0)
            n = 1;
        if (n > MAX_CELLS_PER_AXIS)
            n = MAX_CELLS_PER_AXIS;
        return n;
    endfunction

    // Put the axis with the most nodes outermost; ties go to the third axis,
    // then the second
    function automatic void refresh_strides();
        longint unsigned n0, n1, n2;
        n0 = mesh_nx + 1;
        n1 = mesh_ny + 1;
        n2 = mesh_nz + 1;
        if (n2 >= n0 && n2 >= n1)
        begin
            stride_x = 1;
            stride_y = n0;
            stride_z = n0 * n1;
        end
        else if (n1 >= n0 && n1 >= n2)
        begin
            stride_x = n2;
            stride_y = n0 * n2;
            stride_z = 1;
        end
        else
        begin
            stride_x = n1 * n2;
            stride_y = 1;
            stride_z = n1;
        end
    endfunction

    function automatic elem_t mk_elem(input longint unsigned id, a, b, c, d,
                                      input logic [TAG_W-1:0] tg,
                                      input logic [OWNER_W-1:0] own,
                                      input logic bad, lst);
        elem_t e;
        e.id  = id;
        e.na  = a;
        e.nb  = b;
        e.nc  = c;
        e.nd  = d;
        e.tg  = tg;
        e.own = own;
        e.bad = bad;
        e.lst = lst;
        return e;
    endfunction

    function automatic void add_elem(input longint unsigned id, a, b, c, d,
                                     input logic [TAG_W-1:0] tg, input logic bad, lst);
        request_elements.push_back(mk_elem(id, a, b, c, d, tg, mesh_owner, bad, lst));
    endfunction

    // Work out every element one request yields under the current shadow
    // configuration and leave them in request_elements
    function automatic void predict_elements(input logic [KIND_W-1:0] k,
                                             input logic [COORD_W-1:0] cx, cy, cz);
        longint unsigned gx, gy, gz, n, id, base;
        longint unsigned v [8];
        logic [TAG_W-1:0] tg;
        logic [5:0][2:0]  tc;
        logic             bad;
        logic             even;
        gx = cx;
        gy = cy;
        gz = cz;
        base = 5 * mesh_nx * mesh_ny * mesh_nz;
        request_elements.delete();

        // Only the coordinates the kind actually uses are range checked
        case (k)
            KIND_CELL:             bad = gx >= mesh_nx || gy >= mesh_ny || gz >= mesh_nz;
            KIND_BOTTOM, KIND_TOP: bad = gx >= mesh_nx || gy >= mesh_ny;
            KIND_LEFT, KIND_RIGHT: bad = gy >= mesh_ny || gz >= mesh_nz;
            KIND_FRONT, KIND_BACK: bad = gx >= mesh_nx || gz >= mesh_nz;
            default:               bad = 1'b1;
        endcase
        if (bad)
        begin
            add_elem(0, 0, 0, 0, 0, TAG_CELL, 1'b1, 1'b1);
            return;
        end

        if (k == KIND_CELL)
        begin
            n  = stride_x * gx + stride_y * gy + stride_z * gz;
            id = 5 * (gx + mesh_nx * gy + mesh_nx * mesh_ny * gz);
            if (((gx + gy + gz) & 1) == 0)
            begin
                v[0] = n;
                v[1] = n + stride_x;
                v[2] = n + stride_y;
                v[3] = n + stride_x + stride_y;
                v[4] = n + stride_z;
                v[5] = n + stride_x + stride_z;
                v[6] = n + stride_y + stride_z;
                v[7] = n + stride_x + stride_y + stride_z;
            end
            else
            begin
                // Rotated corners so that odd cells share diagonals with
                // their even neighbors
                v[0] = n + stride_y;
                v[1] = n + stride_x + stride_y;
                v[2] = n + stride_y + stride_z;
                v[3] = n + stride_x + stride_y + stride_z;
                v[4] = n;
                v[5] = n + stride_x;
                v[6] = n + stride_z;
                v[7] = n + stride_x + stride_z;
            end
            add_elem(id,     v[4], v[5], v[6], v[0], TAG_CELL, 1'b0, 1'b0);
            add_elem(id + 1, v[7], v[6], v[5], v[3], TAG_CELL, 1'b0, 1'b0);
            add_elem(id + 2, v[2], v[3], v[0], v[6], TAG_CELL, 1'b0, 1'b0);
            add_elem(id + 3, v[1], v[0], v[3], v[5], TAG_CELL, 1'b0, 1'b0);
            add_elem(id + 4, v[5], v[0], v[6], v[3], TAG_CELL, 1'b0, 1'b1);
            return;
        end

        // Faces: pick the square's base node, its first id and the two corner
        // triples (first triangle in tc[5:3], second in tc[2:0])
        case (k)
            KIND_BOTTOM:
            begin
                n    = stride_x * gx + stride_y * gy;
                id   = base + 2 * (gx + mesh_nx * gy);
                even = ((gx + gy) & 1) == 0;
                tg   = TAG_BOTTOM;
                tc   = even ? {3'd0, 3'd3, 3'd1, 3'd0, 3'd2, 3'd3}
                            : {3'd0, 3'd2, 3'd1, 3'd1, 3'd2, 3'd3};
            end
            KIND_TOP:
            begin
                n    = stride_x * gx + stride_y * gy + stride_z * (mesh_nz - 1);
                id   = base + 2 * mesh_nx * mesh_ny + 2 * (gx + mesh_nx * gy);
                even = ((gx + gy + mesh_nz - 1) & 1) == 0;
                tg   = TAG_TOP;
                tc   = even ? {3'd4, 3'd5, 3'd6, 3'd5, 3'd7, 3'd6}
                            : {3'd4, 3'd5, 3'd7, 3'd4, 3'd7, 3'd6};
            end
            KIND_LEFT:
            begin
                n    = stride_y * gy + stride_z * gz;
                id   = base + 4 * mesh_nx * mesh_ny + 2 * (gy + mesh_ny * gz);
                even = ((gy + gz) & 1) == 0;
                tg   = TAG_LEFT;
                tc   = even ? {3'd0, 3'd4, 3'd6, 3'd0, 3'd6, 3'd2}
                            : {3'd0, 3'd4, 3'd2, 3'd4, 3'd6, 3'd2};
            end
            KIND_RIGHT:
            begin
                n    = stride_x * (mesh_nx - 1) + stride_y * gy + stride_z * gz;
                id   = base + 4 * mesh_nx * mesh_ny + 2 * mesh_ny * mesh_nz
                       + 2 * (gy + mesh_ny * gz);
                even = ((mesh_nx - 1 + gy + gz) & 1) == 0;
                tg   = TAG_RIGHT;
                tc   = even ? {3'd1, 3'd3, 3'd5, 3'd3, 3'd7, 3'd5}
                            : {3'd1, 3'd7, 3'd5, 3'd1, 3'd3, 3'd7};
            end
            KIND_FRONT:
            begin
                n    = stride_x * gx + stride_z * gz;
                id   = base + 4 * mesh_nx * mesh_ny + 4 * mesh_ny * mesh_nz
                       + 2 * (gz + mesh_nz * gx);
                even = ((gx + gz) & 1) == 0;
                tg   = TAG_FRONT;
                tc   = even ? {3'd0, 3'd1, 3'd5, 3'd0, 3'd5, 3'd4}
                            : {3'd0, 3'd1, 3'd4, 3'd1, 3'd5, 3'd4};
            end
            default:
            begin
                n    = stride_x * gx + stride_y * (mesh_ny - 1) + stride_z * gz;
                id   = base + 4 * mesh_nx * mesh_ny + 4 * mesh_ny * mesh_nz
                       + 2 * mesh_nx * mesh_nz + 2 * (gz + mesh_nz * gx);
                even = ((gx + mesh_ny - 1 + gz) & 1) == 0;
                tg   = TAG_BACK;
                tc   = even ? {3'd2, 3'd6, 3'd3, 3'd6, 3'd7, 3'd3}
                            : {3'd2, 3'd6, 3'd7, 3'd2, 3'd7, 3'd3};
            end
        endcase
        for (int c = 0; c < 8; c++)
            v[c] = n + ((c & 1) ? stride_x : 0) + ((c & 2) ? stride_y : 0)
                     + ((c & 4) ? stride_z : 0);
        add_elem(id,     v[tc[5]], v[tc[4]], v[tc[3]], 0, tg, 1'b0, 1'b0);
        add_elem(id + 1, v[tc[2]], v[tc[1]], v[tc[0]], 0, tg, 1'b0, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Directed plan rows
    // ------------------------------------------------------------------

    function automatic plan_row_t cfg_row(input reg_idx_t idx, input logic [DATA_W-1:0] w);
        plan_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.ridx   = idx;
        r.wdata  = w;
        return r;
    endfunction

    function automatic plan_row_t req_row(input logic [KIND_W-1:0] k,
                                          input logic [COORD_W-1:0] x, y, z);
        plan_row_t r;
        r      = '0;
        r.knd  = k;
        r.x    = x;
        r.y    = y;
        r.z    = z;
        return r;
    endfunction

    function automatic plan_row_t exp_row(input logic [KIND_W-1:0] k,
                                          input logic [COORD_W-1:0] x, y, z,
                                          input elem_t e);
        plan_row_t r;
        r       = req_row(k, x, y, z);
        r.typed = 1'b1;
        r.first = e;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    function automatic bit quiet_window();
        return items_sent >= QUIET_FROM && items_sent < QUIET_TO;
    endfunction

    // Register write: setup beat, then access beat; commits on the edge
    // where psel, penable and pready are all high
    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] w);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= w;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CELLS_X: mesh_nx    = clamp_count(w);
            REG_CELLS_Y: mesh_ny    = clamp_count(w);
            REG_CELLS_Z: mesh_nz    = clamp_count(w);
            default:     mesh_owner = w[OWNER_W-1:0];
        endcase
        refresh_strides();
    endtask

    // Drop valid and wait until every owed element has come back, then let
    // the pipeline idle before anything touches the registers
    task automatic drain_results();
        req_valid <= 1'b0;
        while (pending_elements.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Offer one request beat, hold it until accepted, then book its elements
    task automatic send_request(input logic [KIND_W-1:0] k,
                                input logic [COORD_W-1:0] x, y, z,
                                input logic typed, input elem_t first);
        if (!quiet_window() && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid <= 1'b1;
        kind      <= k;
        cell_x    <= x;
        cell_y    <= y;
        cell_z    <= z;
        do @(posedge clk); while (req_stall);
        items_sent <= items_sent + 1;
        predict_elements(k, x, y, z);
        if (typed)
            request_elements[0] = first;
        foreach (request_elements[i])
            pending_elements.push_back(request_elements[i]);
    endtask

    // Count word for one axis: mostly small meshes, with the extremes, the
    // zero-means-one case and saturation mixed in; upper bits are junk
    function automatic logic [DATA_W-1:0] random_count_word();
        logic [DATA_W-1:0] w;
        int                pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:          w = 1;
            1:          w = MAX_CELLS_PER_AXIS;
            2:          w = 0;
            3:          w = $urandom_range(MAX_CELLS_PER_AXIS + 1, 2047);
            4, 5, 6, 7: w = $urandom_range(1, 6);
            default:    w = $urandom_range(1, MAX_CELLS_PER_AXIS);
        endcase
        return ($urandom() & 32'hFFFF_F800) | w;
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall pattern and checking
    // ------------------------------------------------------------------

    // Random stalls, one long hold-off to back the block up into the request
    // side, and a quiet window with no stalls at all
    always @(posedge clk)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
        begin
            if (!hold_done && items_sent >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                res_stall <= 1'b1;
            end
            else if (quiet_window())
                res_stall <= 1'b0;
            else
                res_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    task automatic check_field(input string fname, input longint unsigned want, got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            mismatches = mismatches + 1;
        end
    endtask

    // Compare each accepted result beat with the oldest owed element
    always @(posedge clk)
    begin : result_check
        elem_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_elements.size() == 0)
            begin
                $display("%0t: result beat with nothing owed, actual element_id %0d",
                         $time, element_id);
                mismatches = mismatches + 1;
            end
            else
            begin
                want = pending_elements.pop_front();
                check_field("element_id",  want.id,  element_id);
                check_field("node_a",      want.na,  node_a);
                check_field("node_b",      want.nb,  node_b);
                check_field("node_c",      want.nc,  node_c);
                check_field("node_d",      want.nd,  node_d);
                check_field("tag",         want.tg,  tag);
                check_field("owner",       want.own, owner);
                check_field("bad_request", want.bad, bad_request);
                check_field("last",        want.lst, last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin
        logic [KIND_W-1:0]  k;
        logic [COORD_W-1:0] x, y, z;
        int                 axis;

        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        req_valid = 1'b0;
        kind      = KIND_CELL;
        cell_x    = '0;
        cell_y    = '0;
        cell_z    = '0;
        mesh_nx    = 1;
        mesh_ny    = 1;
        mesh_nz    = 1;
        mesh_owner = '0;
        refresh_strides();

        // Reset geometry: one cell, strides 1, 2, 4, so the first results
        // can be read straight off the corner numbering
        directed_plan.push_back(exp_row(KIND_CELL, 0, 0, 0,
            mk_elem(0, 4, 5, 6, 0, TAG_CELL, 16'h0, 1'b0, 1'b0)));
        directed_plan.push_back(exp_row(KIND_BOTTOM, 0, 0, 1023,
            mk_elem(5, 0, 3, 1, 0, TAG_BOTTOM, 16'h0, 1'b0, 1'b0)));
        directed_plan.push_back(exp_row(KIND_TOP, 0, 0, 0,
            mk_elem(7, 4, 5, 6, 0, TAG_TOP, 16'h0, 1'b0, 1'b0)));
        directed_plan.push_back(exp_row(KIND_LEFT, 1023, 0, 0,
            mk_elem(9, 0, 4, 6, 0, TAG_LEFT, 16'h0, 1'b0, 1'b0)));
        directed_plan.push_back(exp_row(KIND_RIGHT, 0, 0, 0,
            mk_elem(11, 1, 3, 5, 0, TAG_RIGHT, 16'h0, 1'b0, 1'b0)));
        directed_plan.push_back(exp_row(KIND_FRONT, 0, 1023, 0,
            mk_elem(13, 0, 1, 5, 0, TAG_FRONT, 16'h0, 1'b0, 1'b0)));
        directed_plan.push_back(exp_row(KIND_BACK, 0, 0, 0,
            mk_elem(15, 2, 6, 3, 0, TAG_BACK, 16'h0, 1'b0, 1'b0)));
        directed_plan.push_back(exp_row(KIND_UNUSED, 0, 0, 0,
            mk_elem(0, 0, 0, 0, 0, TAG_CELL, 16'h0, 1'b1, 1'b1)));
        directed_plan.push_back(exp_row(KIND_CELL, 1, 0, 0,
            mk_elem(0, 0, 0, 0, 0, TAG_CELL, 16'h0, 1'b1, 1'b1)));
        directed_plan.push_back(exp_row(KIND_BOTTOM, 0, 1, 0,
            mk_elem(0, 0, 0, 0, 0, TAG_CELL, 16'h0, 1'b1, 1'b1)));

        // Thin slab: zero count acts as one, oversize counts saturate,
        // junk above the count and owner fields is dropped
        directed_plan.push_back(cfg_row(REG_CELLS_X, 32'hFFFF_F800));
        directed_plan.push_back(cfg_row(REG_CELLS_Y, 32'h0000_07D0));
        directed_plan.push_back(cfg_row(REG_CELLS_Z, 32'h0000_0400));
        directed_plan.push_back(cfg_row(REG_OWNER,   32'hFFFF_FFFF));
        directed_plan.push_back(req_row(KIND_CELL, 0, 1023, 1023));
        directed_plan.push_back(req_row(KIND_CELL, 0, 1022, 1023));
        directed_plan.push_back(req_row(KIND_TOP, 0, 1023, 0));
        directed_plan.push_back(req_row(KIND_RIGHT, 512, 1023, 1023));
        directed_plan.push_back(req_row(KIND_BACK, 0, 1023, 1022));
        directed_plan.push_back(exp_row(KIND_FRONT, 1, 0, 0,
            mk_elem(0, 0, 0, 0, 0, TAG_CELL, 16'hFFFF, 1'b1, 1'b1)));

        // Largest mesh: top element and node ids, all three axis counts tied
        directed_plan.push_back(cfg_row(REG_CELLS_X, 32'h0000_0400));
        directed_plan.push_back(cfg_row(REG_CELLS_Y, 32'h0000_0400));
        directed_plan.push_back(cfg_row(REG_CELLS_Z, 32'h0000_07FF));
        directed_plan.push_back(cfg_row(REG_OWNER,   32'h0000_1234));
        directed_plan.push_back(req_row(KIND_CELL, 1023, 1023, 1023));
        directed_plan.push_back(req_row(KIND_BOTTOM, 1023, 1023, 1023));
        directed_plan.push_back(req_row(KIND_BACK, 1023, 0, 1023));
        directed_plan.push_back(req_row(KIND_LEFT, 0, 1023, 1022));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[r])
        begin
            if (directed_plan[r].is_cfg)
            begin
                drain_results();
                write_reg(directed_plan[r].ridx, directed_plan[r].wdata);
            end
            else
                send_request(directed_plan[r].knd, directed_plan[r].x, directed_plan[r].y,
                             directed_plan[r].z, directed_plan[r].typed,
                             directed_plan[r].first);
        end

        // Random phases: new geometry and owner each time, then a run of
        // mostly legal requests with some out-of-range and unused kinds
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            drain_results();
            write_reg(REG_CELLS_X, random_count_word());
            write_reg(REG_CELLS_Y, random_count_word());
            write_reg(REG_CELLS_Z, random_count_word());
            write_reg(REG_OWNER, $urandom());
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                axis = $urandom_range(0, 99);
                if (axis < 35)
                    k = KIND_CELL;
                else if (axis < 95)
                    k = $urandom_range(KIND_BOTTOM, KIND_BACK);
                else
                    k = KIND_UNUSED;
                x = $urandom_range(0, int'(mesh_nx) - 1);
                y = $urandom_range(0, int'(mesh_ny) - 1);
                z = $urandom_range(0, int'(mesh_nz) - 1);
                // Scramble the coordinate the face does not use
                case (k)
                    KIND_BOTTOM, KIND_TOP: z = $urandom_range(0, 1023);
                    KIND_LEFT, KIND_RIGHT: x = $urandom_range(0, 1023);
                    KIND_FRONT, KIND_BACK: y = $urandom_range(0, 1023);
                    default: ;
                endcase
                // Push one axis past its count now and then
                if ($urandom_range(0, 99) < 10)
                begin
                    axis = $urandom_range(0, 2);
                    if (axis == 0 && mesh_nx < MAX_CELLS_PER_AXIS)
                        x = $urandom_range(int'(mesh_nx), 1023);
                    else if (axis == 1 && mesh_ny < MAX_CELLS_PER_AXIS)
                        y = $urandom_range(int'(mesh_ny), 1023);
                    else if (axis == 2 && mesh_nz < MAX_CELLS_PER_AXIS)
                        z = $urandom_range(int'(mesh_nz), 1023);
                end
                send_request(k, x, y, z, 1'b0, '0);
            end
        end

        req_valid <= 1'b0;
        while (pending_elements.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #TIMEOUT;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
sv/htm_pkg.sv
sv/htm_cfg.sv
sv/htm_front.sv
sv/htm_queue.sv
sv/htm_back.sv
sv/hex_to_tet_mesh_connectivity_unit.sv
dv/tb_hex_to_tet_mesh_connectivity_unit.sv
